/* sv/cll_pkg.sv */
// ----------------------------------------------------------------------------
// Lexer package
// Transaction types, token kind codes, character constants and the
// keyword matcher shared by the lexer.
// ----------------------------------------------------------------------------
package cll_pkg;

  // One source byte per transaction.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } src_item_t;

  // One token per transaction.
  typedef struct packed {
    logic [4:0]  token_kind;
    logic [31:0] int_value;
    logic [15:0] ident_offset;
    logic [15:0] ident_length;
    logic        unexpected_char;
    logic        last_result;
  } tok_item_t;

  // Token kinds.
  localparam logic [4:0] K_INT    = 5'd0;
  localparam logic [4:0] K_IDENT  = 5'd1;
  localparam logic [4:0] K_IF     = 5'd2;
  localparam logic [4:0] K_FOR    = 5'd3;
  localparam logic [4:0] K_ELSE   = 5'd4;
  localparam logic [4:0] K_WHILE  = 5'd5;
  localparam logic [4:0] K_RETURN = 5'd6;
  localparam logic [4:0] K_PLUS   = 5'd7;
  localparam logic [4:0] K_POS    = 5'd8;
  localparam logic [4:0] K_MINUS  = 5'd9;
  localparam logic [4:0] K_NEG    = 5'd10;
  localparam logic [4:0] K_MUL    = 5'd11;
  localparam logic [4:0] K_DIV    = 5'd12;
  localparam logic [4:0] K_LPAR   = 5'd13;
  localparam logic [4:0] K_RPAR   = 5'd14;
  localparam logic [4:0] K_LT     = 5'd15;
  localparam logic [4:0] K_LE     = 5'd16;
  localparam logic [4:0] K_GT     = 5'd17;
  localparam logic [4:0] K_GE     = 5'd18;
  localparam logic [4:0] K_NE     = 5'd19;
  localparam logic [4:0] K_ASSIGN = 5'd20;
  localparam logic [4:0] K_EQ     = 5'd21;
  localparam logic [4:0] K_SEMI   = 5'd22;
  localparam logic [4:0] K_LBRACE = 5'd23;
  localparam logic [4:0] K_RBRACE = 5'd24;
  localparam logic [4:0] K_AMP    = 5'd25;

  // Characters.
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_NINE   = "9";
  localparam logic [7:0] CH_A_UP   = "A";
  localparam logic [7:0] CH_Z_UP   = "Z";
  localparam logic [7:0] CH_A_LO   = "a";
  localparam logic [7:0] CH_Z_LO   = "z";
  localparam logic [7:0] CH_UNDER  = "_";
  localparam logic [7:0] CH_SPACE  = " ";
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LT     = "<";
  localparam logic [7:0] CH_GT     = ">";
  localparam logic [7:0] CH_BANG   = "!";
  localparam logic [7:0] CH_EQ     = "=";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_LPAR   = "(";
  localparam logic [7:0] CH_RPAR   = ")";
  localparam logic [7:0] CH_SEMI   = ";";
  localparam logic [7:0] CH_LBRACE = "{";
  localparam logic [7:0] CH_RBRACE = "}";
  localparam logic [7:0] CH_AMP    = "&";

  localparam logic [31:0] DEC_BASE = 32'd10;

  // Keyword spellings, first character in the top byte.
  localparam logic [15:0] KW_IF     = "if";
  localparam logic [23:0] KW_FOR    = "for";
  localparam logic [31:0] KW_ELSE   = "else";
  localparam logic [39:0] KW_WHILE  = "while";
  localparam logic [47:0] KW_RETURN = "return";

  // Width in bytes of the word prefix passed to the matcher.
  localparam int KW_SLOTS = 8;
  typedef logic [KW_SLOTS-1:0][7:0] kw_prefix_t;

  function automatic logic is_numeral(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= CH_A_UP) && (b <= CH_Z_UP)) || ((b >= CH_A_LO) && (b <= CH_Z_LO)) ||
           (b == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  // Identifier or keyword kind of a word, from its length and first bytes.
  function automatic logic [4:0] word_kind(input kw_prefix_t pre, input logic [15:0] len);
    if ((len == 16'd2) && ({pre[0], pre[1]} == KW_IF)) return K_IF;
    if ((len == 16'd3) && ({pre[0], pre[1], pre[2]} == KW_FOR)) return K_FOR;
    if ((len == 16'd4) && ({pre[0], pre[1], pre[2], pre[3]} == KW_ELSE)) return K_ELSE;
    if ((len == 16'd5) && ({pre[0], pre[1], pre[2], pre[3], pre[4]} == KW_WHILE))
      return K_WHILE;
    if ((len == 16'd6) &&
        ({pre[0], pre[1], pre[2], pre[3], pre[4], pre[5]} == KW_RETURN))
      return K_RETURN;
    return K_IDENT;
  endfunction

  function automatic tok_item_t make_tok(input logic [4:0] kind, input logic [31:0] val,
                                         input logic [15:0] off, input logic [15:0] len);
    tok_item_t t;
    t.token_kind      = kind;
    t.int_value       = val;
    t.ident_offset    = off;
    t.ident_length    = len;
    t.unexpected_char = 1'b0;
    t.last_result     = 1'b0;
    return t;
  endfunction

  function automatic tok_item_t make_err();
    tok_item_t t;
    t = make_tok(K_INT, 32'd0, 16'd0, 16'd0);
    t.unexpected_char = 1'b1;
    t.last_result     = 1'b1;
    return t;
  endfunction

endpackage

/* sv/c_like_lexer.sv */
// ----------------------------------------------------------------------------
// C-like lexer
// Streaming tokenizer: one source byte in per transaction, integer,
// identifier, keyword and operator tokens out.
// ----------------------------------------------------------------------------
// The lexer takes one byte of source text per cycle and produces tokens on
// the result channel. A byte is registered at the input, classified against
// the pending token by a single stage of logic, and its tokens (none, one or
// two) are written into a two-entry result register. A byte that yields at
// most one token lets the next byte enter in the following cycle, so the
// sustained rate is one byte per cycle while tok_stall is low; a byte that
// yields two tokens holds the input while the second entry drains.
// Multi-byte tokens (numbers, words, and <, >, !, = which may pair with a
// following '=') are held until a byte arrives that cannot continue them,
// or until the byte flagged end_of_text, which closes the text and returns
// the lexer to its reset state. An unexpected character (including a '!'
// not followed by '=') produces one error transaction carrying last_result;
// all further bytes up to and including end_of_text are then dropped
// without results.
// There is no start-up sweep: the lexer is ready straight after reset.
// ----------------------------------------------------------------------------
module c_like_lexer #(
  parameter int MAX_TEXT        = 65536,
  parameter int KEYWORD_MAX_LEN = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_stall,
  input  cll_pkg::src_item_t   src,
  output logic                 tok_valid,
  input  logic                 tok_stall,
  output cll_pkg::tok_item_t   tok
);
  import cll_pkg::*;

  localparam int POS_W = $clog2(MAX_TEXT);
  localparam int IDX_W = $clog2(KEYWORD_MAX_LEN);
  localparam logic [15:0] PREFIX_DEPTH = 16'(KEYWORD_MAX_LEN);
  localparam logic [15:0] LEN_SAT     = 16'hFFFF;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_TEXT - 1);

  // Kind of the token still being collected.
  typedef enum logic [2:0] {
    P_NONE, P_INT, P_WORD, P_LT, P_GT, P_BANG, P_ASSIGN
  } pend_t;

  typedef logic [KEYWORD_MAX_LEN-1:0][7:0] prefix_t;

  // Control registers.
  logic             s1_valid;
  logic [1:0]       cnt;
  pend_t            pend;
  logic             operand;
  logic [POS_W-1:0] pos;
  logic             discarding;

  // Payload registers.
  src_item_t        s1;
  logic [31:0]      acc;
  logic [15:0]      word_start;
  logic [15:0]      word_len;
  prefix_t          prefix;
  tok_item_t        slot [2];

  // Next values.
  pend_t            pend_next;
  logic             operand_next;
  logic [POS_W-1:0] pos_next;
  logic [31:0]      acc_next;
  logic [15:0]      word_start_next;
  logic [15:0]      word_len_next;
  prefix_t          prefix_next;
  tok_item_t        slot_next [2];
  logic [1:0]       cnt_next;

  logic             take;
  logic             consume;
  logic             src_accept;
  logic             err;

  function automatic kw_prefix_t widen(input prefix_t p);
    kw_prefix_t w;
    w = '0;
    for (int i = 0; i < KEYWORD_MAX_LEN; i++) w[i] = p[i];
    return w;
  endfunction

  assign tok_valid  = (cnt != 2'd0);
  assign tok        = slot[0];
  assign take       = tok_valid && !tok_stall;
  // A byte may be worked on once the result register is empty, or is
  // emptied by this cycle's output transaction.
  assign consume    = s1_valid && ((cnt == 2'd0) || ((cnt == 2'd1) && take));
  assign src_stall  = s1_valid && !consume;
  assign src_accept = src_valid && !src_stall;
  assign pos_next   = (pos == POS_LAST) ? '0 : pos + 1'b1;

  always_comb begin
    logic [7:0]  b;
    logic        eot;
    logic        combine, cont_int, cont_word;
    logic [4:0]  comb_kind;
    logic [31:0] digit_val;
    logic        flush_put, flush_err, operand_mid;
    tok_item_t   flush_tok;
    logic        st_put, st_err;
    logic [4:0]  st_kind;
    logic        end_put, end_err;
    tok_item_t   end_tok;
    tok_item_t   cand [4];
    logic [3:0]  cv;

    b         = s1.text_byte;
    eot       = s1.end_of_text;
    digit_val = {28'd0, b[3:0]};

    pend_next       = pend;
    operand_next    = operand;
    acc_next        = acc;
    word_start_next = word_start;
    word_len_next   = word_len;
    prefix_next     = prefix;

    flush_put   = 1'b0;
    flush_err   = 1'b0;
    flush_tok   = make_tok(K_INT, 32'd0, 16'd0, 16'd0);
    operand_mid = operand;
    st_put      = 1'b0;
    st_err      = 1'b0;
    st_kind     = K_INT;
    end_put     = 1'b0;
    end_err     = 1'b0;
    end_tok     = make_tok(K_INT, 32'd0, 16'd0, 16'd0);

    combine   = (b == CH_EQ) &&
                ((pend == P_LT) || (pend == P_GT) || (pend == P_BANG) || (pend == P_ASSIGN));
    cont_int  = (pend == P_INT) && is_numeral(b);
    cont_word = (pend == P_WORD) && (is_letter(b) || is_numeral(b));

    case (pend)
      P_LT:    comb_kind = K_LE;
      P_GT:    comb_kind = K_GE;
      P_BANG:  comb_kind = K_NE;
      default: comb_kind = K_EQ;
    endcase

    if (combine) begin
      pend_next    = P_NONE;
      operand_next = 1'b0;
    end else if (cont_int) begin
      acc_next = 32'(acc * DEC_BASE) + digit_val;
    end else if (cont_word) begin
      if (word_len < PREFIX_DEPTH) prefix_next[word_len[IDX_W-1:0]] = b;
      if (word_len != LEN_SAT) word_len_next = word_len + 16'd1;
    end else begin
      // The pending token ends here; emit it, then start a new one.
      pend_next = P_NONE;
      case (pend)
        P_INT: begin
          flush_put = 1'b1;
          flush_tok = make_tok(K_INT, acc, 16'd0, 16'd0);
        end
        P_WORD: begin
          flush_put = 1'b1;
          flush_tok = make_tok(word_kind(widen(prefix), word_len), 32'd0, word_start,
                               word_len);
        end
        P_LT: begin
          flush_put = 1'b1;
          flush_tok = make_tok(K_LT, 32'd0, 16'd0, 16'd0);
        end
        P_GT: begin
          flush_put = 1'b1;
          flush_tok = make_tok(K_GT, 32'd0, 16'd0, 16'd0);
        end
        P_ASSIGN: begin
          flush_put = 1'b1;
          flush_tok = make_tok(K_ASSIGN, 32'd0, 16'd0, 16'd0);
        end
        P_BANG:  flush_err = 1'b1;
        default: ;
      endcase
      if (flush_put) begin
        operand_mid = (flush_tok.token_kind == K_INT) || (flush_tok.token_kind == K_IDENT);
      end

      if (!flush_err) begin
        if (is_space(b)) begin
          st_put = 1'b0;
        end else if (is_numeral(b)) begin
          pend_next = P_INT;
          acc_next  = digit_val;
        end else if (is_letter(b)) begin
          pend_next       = P_WORD;
          word_start_next = 16'(pos);
          word_len_next   = 16'd1;
          prefix_next[0]  = b;
        end else begin
          case (b)
            CH_LT:     pend_next = P_LT;
            CH_GT:     pend_next = P_GT;
            CH_BANG:   pend_next = P_BANG;
            CH_EQ:     pend_next = P_ASSIGN;
            CH_PLUS: begin
              st_put  = 1'b1;
              st_kind = operand_mid ? K_PLUS : K_POS;
            end
            CH_MINUS: begin
              st_put  = 1'b1;
              st_kind = operand_mid ? K_MINUS : K_NEG;
            end
            CH_STAR: begin
              st_put  = 1'b1;
              st_kind = K_MUL;
            end
            CH_SLASH: begin
              st_put  = 1'b1;
              st_kind = K_DIV;
            end
            CH_LPAR: begin
              st_put  = 1'b1;
              st_kind = K_LPAR;
            end
            CH_RPAR: begin
              st_put  = 1'b1;
              st_kind = K_RPAR;
            end
            CH_SEMI: begin
              st_put  = 1'b1;
              st_kind = K_SEMI;
            end
            CH_LBRACE: begin
              st_put  = 1'b1;
              st_kind = K_LBRACE;
            end
            CH_RBRACE: begin
              st_put  = 1'b1;
              st_kind = K_RBRACE;
            end
            CH_AMP: begin
              st_put  = 1'b1;
              st_kind = K_AMP;
            end
            default: st_err = 1'b1;
          endcase
        end
      end
      operand_next = st_put ? 1'b0 : operand_mid;
    end

    // The final byte also closes whatever token it leaves pending.
    if (!flush_err && !st_err && eot) begin
      case (pend_next)
        P_INT: begin
          end_put = 1'b1;
          end_tok = make_tok(K_INT, acc_next, 16'd0, 16'd0);
        end
        P_WORD: begin
          end_put = 1'b1;
          end_tok = make_tok(word_kind(widen(prefix_next), word_len_next), 32'd0,
                             word_start_next, word_len_next);
        end
        P_LT: begin
          end_put = 1'b1;
          end_tok = make_tok(K_LT, 32'd0, 16'd0, 16'd0);
        end
        P_GT: begin
          end_put = 1'b1;
          end_tok = make_tok(K_GT, 32'd0, 16'd0, 16'd0);
        end
        P_ASSIGN: begin
          end_put = 1'b1;
          end_tok = make_tok(K_ASSIGN, 32'd0, 16'd0, 16'd0);
        end
        P_BANG:  end_err = 1'b1;
        default: ;
      endcase
    end

    err = flush_err || st_err || end_err;

    // Tokens in output order; at most two are present for any byte.
    cand[0] = combine ? make_tok(comb_kind, 32'd0, 16'd0, 16'd0) : flush_tok;
    cand[1] = make_tok(st_kind, 32'd0, 16'd0, 16'd0);
    cand[2] = end_tok;
    cand[3] = make_err();
    cv      = {err, end_put, st_put, combine || flush_put};

    slot_next[0] = cand[0];
    slot_next[1] = cand[1];
    cnt_next     = 2'd0;
    if (!discarding) begin
      for (int i = 0; i < 4; i++) begin
        if (cv[i]) begin
          if (cnt_next == 2'd0) slot_next[0] = cand[i];
          else                  slot_next[1] = cand[i];
          cnt_next = cnt_next + 2'd1;
        end
      end
    end
    if (eot && (cnt_next == 2'd2)) slot_next[1].last_result = 1'b1;
    if (eot && (cnt_next == 2'd1)) slot_next[0].last_result = 1'b1;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      cnt        <= 2'd0;
      pend       <= P_NONE;
      operand    <= 1'b0;
      pos        <= '0;
      discarding <= 1'b0;
    end else begin
      if (src_accept)   s1_valid <= 1'b1;
      else if (consume) s1_valid <= 1'b0;

      if (consume)   cnt <= cnt_next;
      else if (take) cnt <= cnt - 2'd1;

      if (consume) begin
        if (s1.end_of_text) begin
          // Every text closes into a fresh run, error or not.
          pend       <= P_NONE;
          operand    <= 1'b0;
          pos        <= '0;
          discarding <= 1'b0;
        end else if (discarding) begin
          discarding <= 1'b1;
        end else if (err) begin
          discarding <= 1'b1;
        end else begin
          pend    <= pend_next;
          operand <= operand_next;
          pos     <= pos_next;
        end
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (src_accept) s1 <= src;
    if (consume) begin
      acc        <= acc_next;
      word_start <= word_start_next;
      word_len   <= word_len_next;
      prefix     <= prefix_next;
      slot[0]    <= slot_next[0];
      slot[1]    <= slot_next[1];
    end else if (take) begin
      slot[0] <= slot[1];
    end
  end

  // The result register never holds more than two tokens.
  assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result register overfilled");

  // Bytes dropped after an error produce nothing.
  assert property (@(posedge clk) disable iff (rst) (consume && discarding) |=> !tok_valid)
    else $error("token produced while discarding");

  // An error transaction always closes the run.
  assert property (@(posedge clk) disable iff (rst)
                   (tok_valid && tok.unexpected_char) |-> tok.last_result)
    else $error("error transaction without last_result");

  // The final byte returns the lexer to its reset state.
  assert property (@(posedge clk) disable iff (rst)
                   (consume && s1.end_of_text) |=>
                   ((pend == P_NONE) && !discarding && (pos == '0) && !operand))
    else $error("run not closed after end of text");

endmodule
